@@ rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg
// shared widths, codes and types of the can bit timing search unit
// ----------------------------------------------------------------------------
package bts_pkg;

   // field widths
   localparam int RATE_W     = 20;
   localparam int QUANTA_W   = 5;
   localparam int CLOCK_W    = 32;
   localparam int PERCENT_W  = 7;
   localparam int PRESC_W    = 20;
   localparam int JUMP_W     = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // shared divider widths
   localparam int DIVIDEND_W = CLOCK_W;
   localparam int DIVISOR_W  = RATE_W + QUANTA_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // search range and limits
   localparam logic [QUANTA_W-1:0]   MAX_QUANTA     = QUANTA_W'(25);
   localparam logic [QUANTA_W-1:0]   MIN_QUANTA     = QUANTA_W'(8);
   localparam int                    FIT_SHIFT      = 5;
   localparam logic [DIVIDEND_W-1:0] PRESC_LIMIT    = DIVIDEND_W'(1024);
   localparam logic [QUANTA_W-1:0]   SJW_SEG2_LIMIT = QUANTA_W'(5);
   localparam logic [JUMP_W-1:0]     SJW_MAX        = JUMP_W'(4);

   // sample point divide by 100 as a reciprocal multiply, exact for q * percent
   // up to 25 * 127
   localparam int                    SP_PROD_W      = QUANTA_W + PERCENT_W;
   localparam int                    SP_RECIP_W     = 13;
   localparam logic [SP_RECIP_W-1:0] SP_RECIP       = SP_RECIP_W'(5243);
   localparam int                    SP_RECIP_SHIFT = 19;
   localparam int                    SP_SCALED_W    = SP_RECIP_SHIFT + QUANTA_W;

   // reset values of the registers
   localparam logic [CLOCK_W-1:0]   CLOCK_HZ_RESET = CLOCK_W'(42000000);
   localparam logic [PERCENT_W-1:0] PERCENT_RESET  = PERCENT_W'(87);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_POINT = CSR_IDX_W'(1);

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FIT    = 2'd1,
      STATUS_ZERO_RATE = 2'd2,
      STATUS_PRESC_BIG = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIAL,
      ST_DIV_WAIT,
      ST_TEST,
      ST_SP_WAIT,
      ST_RESULT
   } state_type;

   // divider command and response
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

@@ rtl/can_bit_timing_search_unit.sv @@
// ----------------------------------------------------------------------------
// can_bit_timing_search_unit
// searches quanta per bit for a requested can bit rate and derives timing
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_bit_rate
//  rsp     | out       | rsp_valid / rsp_ready  | status, prescaler, segments, rate
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
//  one item tries quanta counts from 25 down to 8 (1 to 18 counts), stopping at
//  the first that fits. each trial is a start state, the 32-step serial divider
//  and a test state. a zero rate skips the divider.
//  req_ready is high only while the sequencer is idle; a result waits in the
//  output register while the next beat is taken.
//  synchronous active-high reset; csr_ready is always high.
// ----------------------------------------------------------------------------
module can_bit_timing_search_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bts_pkg::RATE_W-1:0]        req_bit_rate,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [bts_pkg::PRESC_W-1:0]       rsp_prescaler,
   output logic [bts_pkg::QUANTA_W-1:0]      rsp_quanta_per_bit,
   output logic [bts_pkg::QUANTA_W-1:0]      rsp_sample_quanta,
   output logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_one,
   output logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_two,
   output logic [bts_pkg::JUMP_W-1:0]        rsp_jump_width,
   output logic                              rsp_segments_in_range,
   output logic [bts_pkg::RATE_W-1:0]        rsp_real_rate,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]    csr_data
);

   bts_pkg::state_type                 state_ff, state_in;
   bts_pkg::status_type                status_ff, status_in;
   logic [bts_pkg::CLOCK_W-1:0]        clock_hz_ff;
   logic [bts_pkg::PERCENT_W-1:0]      percent_ff;
   logic [bts_pkg::RATE_W-1:0]         rate_ff, rate_in;
   logic [bts_pkg::QUANTA_W-1:0]       q_ff, q_in;
   logic [bts_pkg::DIVISOR_W-1:0]      fq_ff, fq_in;
   logic [bts_pkg::PRESC_W-1:0]        presc_ff, presc_in;
   logic [bts_pkg::SP_PROD_W-1:0]      sp_prod_ff, sp_prod_in;
   logic [bts_pkg::QUANTA_W-1:0]       sp_raw_ff, sp_raw_in;

   bts_pkg::div_cmd_type               div_cmd;
   bts_pkg::div_rsp_type               div_rsp;

   logic                               req_beat;
   logic                               out_free;
   logic                               rate_zero;
   logic                               fit;
   logic                               last_q;
   logic [bts_pkg::DIVISOR_W-1:0]      fq_prod;
   logic [bts_pkg::SP_PROD_W-1:0]      sp_prod;
   logic [bts_pkg::SP_SCALED_W-1:0]    sp_scaled;

   // result fields
   logic [bts_pkg::QUANTA_W-1:0]       sp, seg1, seg2;
   logic [bts_pkg::JUMP_W-1:0]         sjw;
   logic                               in_range;
   logic [bts_pkg::RATE_W-1:0]         real_rate;
   logic                               found;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         status_out_ff;
   logic [bts_pkg::PRESC_W-1:0]        presc_out_ff;
   logic [bts_pkg::QUANTA_W-1:0]       q_out_ff, sp_out_ff, seg1_out_ff, seg2_out_ff;
   logic [bts_pkg::JUMP_W-1:0]         sjw_out_ff;
   logic                               range_out_ff;
   logic [bts_pkg::RATE_W-1:0]         real_out_ff;
   logic                               load_out;

   // shared divider
   bts_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= bts_pkg::CLOCK_HZ_RESET;
         percent_ff  <= bts_pkg::PERCENT_RESET;
      end else if (csr_valid) begin
         if (csr_index == bts_pkg::CSR_CLOCK_HZ)
            clock_hz_ff <= csr_data[bts_pkg::CLOCK_W-1:0];
         else if (csr_index == bts_pkg::CSR_SAMPLE_POINT)
            percent_ff <= csr_data[bts_pkg::PERCENT_W-1:0];
      end
   end

   // trial products and fit test
   always_comb begin
      req_beat  = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;
      rate_zero = rate_ff == '0;
      fq_prod   = bts_pkg::DIVISOR_W'(rate_ff) * bts_pkg::DIVISOR_W'(q_ff);
      sp_prod   = bts_pkg::SP_PROD_W'(q_ff) * bts_pkg::SP_PROD_W'(percent_ff);
      sp_scaled = bts_pkg::SP_SCALED_W'(sp_prod_ff) * bts_pkg::SP_SCALED_W'(bts_pkg::SP_RECIP);
      fit       = div_rsp.remainder < (fq_ff >> bts_pkg::FIT_SHIFT);
      last_q    = q_ff == bts_pkg::MIN_QUANTA;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bts_pkg::ST_IDLE:
            if (req_beat) state_in = bts_pkg::ST_TRIAL;
         bts_pkg::ST_TRIAL:
            state_in = rate_zero ? bts_pkg::ST_RESULT : bts_pkg::ST_DIV_WAIT;
         bts_pkg::ST_DIV_WAIT:
            if (div_rsp.done) state_in = bts_pkg::ST_TEST;
         bts_pkg::ST_TEST:
            if (fit) state_in = bts_pkg::ST_SP_WAIT;
            else if (last_q) state_in = bts_pkg::ST_RESULT;
            else state_in = bts_pkg::ST_TRIAL;
         bts_pkg::ST_SP_WAIT:
            state_in = bts_pkg::ST_RESULT;
         bts_pkg::ST_RESULT:
            if (out_free) state_in = bts_pkg::ST_IDLE;
         default:
            state_in = bts_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and working registers
   always_comb begin
      req_ready        = 1'b0;
      load_out         = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = clock_hz_ff;
      div_cmd.divisor  = fq_prod;
      rate_in          = rate_ff;
      q_in             = q_ff;
      fq_in            = fq_ff;
      presc_in         = presc_ff;
      status_in        = status_ff;
      sp_prod_in       = sp_prod_ff;
      sp_raw_in        = sp_raw_ff;
      case (state_ff)
         bts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rate_in   = req_bit_rate;
            q_in      = bts_pkg::MAX_QUANTA;
            status_in = bts_pkg::STATUS_OK;
         end
         bts_pkg::ST_TRIAL: begin
            fq_in = fq_prod;
            if (rate_zero) status_in = bts_pkg::STATUS_ZERO_RATE;
            else div_cmd.start = 1'b1;
         end
         bts_pkg::ST_TEST: begin
            if (fit) begin
               sp_prod_in = sp_prod;
               presc_in = (|div_rsp.quotient[bts_pkg::DIVIDEND_W-1:bts_pkg::PRESC_W])
                        ? '1 : div_rsp.quotient[bts_pkg::PRESC_W-1:0];
               status_in = (div_rsp.quotient > bts_pkg::PRESC_LIMIT)
                         ? bts_pkg::STATUS_PRESC_BIG : bts_pkg::STATUS_OK;
            end else if (last_q) begin
               status_in = bts_pkg::STATUS_NO_FIT;
            end else begin
               q_in = q_ff - 1'b1;
            end
         end
         // sample point in quanta, q * percent over 100
         bts_pkg::ST_SP_WAIT:
            sp_raw_in = sp_scaled[bts_pkg::SP_RECIP_SHIFT +: bts_pkg::QUANTA_W];
         bts_pkg::ST_RESULT:
            load_out = out_free;
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) state_ff <= bts_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      rate_ff    <= rate_in;
      q_ff       <= q_in;
      fq_ff      <= fq_in;
      presc_ff   <= presc_in;
      status_ff  <= status_in;
      sp_prod_ff <= sp_prod_in;
      sp_raw_ff  <= sp_raw_in;
   end

   // segment split from the sample point quotient
   always_comb begin
      found    = status_ff == bts_pkg::STATUS_OK || status_ff == bts_pkg::STATUS_PRESC_BIG;
      sp       = (sp_raw_ff > q_ff) ? q_ff : sp_raw_ff;
      seg2     = q_ff - sp;
      seg1     = (sp == '0) ? '0 : sp - 1'b1;
      if (seg2 > bts_pkg::SJW_SEG2_LIMIT) sjw = bts_pkg::SJW_MAX;
      else if (seg2 == '0) sjw = '0;
      else sjw = seg2[bts_pkg::JUMP_W-1:0] - 1'b1;
      in_range = (seg1 inside {[1:16]}) && (seg2 inside {[1:8]}) && (sjw inside {[1:4]});
      // quantum frequency over q quanta is the requested rate itself
      real_rate = (seg1 != '0 && seg2 != '0) ? rate_ff : '0;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         status_out_ff <= status_ff;
         presc_out_ff  <= found ? presc_ff : '0;
         q_out_ff      <= found ? q_ff : '0;
         sp_out_ff     <= found ? sp : '0;
         seg1_out_ff   <= found ? seg1 : '0;
         seg2_out_ff   <= found ? seg2 : '0;
         sjw_out_ff    <= found ? sjw : '0;
         range_out_ff  <= found && in_range;
         real_out_ff   <= found ? real_rate : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_out_ff;
   assign rsp_prescaler         = presc_out_ff;
   assign rsp_quanta_per_bit    = q_out_ff;
   assign rsp_sample_quanta     = sp_out_ff;
   assign rsp_segment_one       = seg1_out_ff;
   assign rsp_segment_two       = seg2_out_ff;
   assign rsp_jump_width        = sjw_out_ff;
   assign rsp_segments_in_range = range_out_ff;
   assign rsp_real_rate         = real_out_ff;

endmodule

@@ rtl/bts_divider.sv @@
// ----------------------------------------------------------------------------
// bts_divider
// restoring serial divider, one quotient bit per cycle, shared by all trials
// ----------------------------------------------------------------------------
module bts_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bts_pkg::div_cmd_type cmd,
   output bts_pkg::div_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [bts_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bts_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [bts_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [bts_pkg::DIVISOR_W-1:0]     div_ff, div_in;
   logic [bts_pkg::DIVISOR_W:0]       trial;
   logic [bts_pkg::DIVISOR_W:0]       diff;
   logic                              fits;

   // trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[bts_pkg::DIVIDEND_W-1]};
      fits  = trial >= {1'b0, div_ff};
      diff  = trial - {1'b0, div_ff};
   end

   // next values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = cmd.dividend;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[bts_pkg::DIVISOR_W-1:0] : trial[bts_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[bts_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bts_pkg::DIV_CNT_W'(bts_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ rtl/bts_checker.sv @@
// ----------------------------------------------------------------------------
// bts_checker
// port-level checks of the can bit timing search unit
// ----------------------------------------------------------------------------
module bts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [bts_pkg::RATE_W-1:0]        req_bit_rate,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic [bts_pkg::PRESC_W-1:0]       rsp_prescaler,
   input logic [bts_pkg::QUANTA_W-1:0]      rsp_quanta_per_bit,
   input logic [bts_pkg::QUANTA_W-1:0]      rsp_sample_quanta,
   input logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_one,
   input logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_two,
   input logic [bts_pkg::JUMP_W-1:0]        rsp_jump_width,
   input logic                              rsp_segments_in_range,
   input logic [bts_pkg::RATE_W-1:0]        rsp_real_rate,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [bts_pkg::CSR_DATA_W-1:0]    csr_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_prescaler) && $stable(rsp_quanta_per_bit))
      else $error("result beat changed while stalled");

   // the search occupies the block after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while search running");

   // failed searches report nothing but the status
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bts_pkg::STATUS_NO_FIT ||
                    rsp_status == bts_pkg::STATUS_ZERO_RATE) |->
      rsp_prescaler == '0 && rsp_quanta_per_bit == '0 && rsp_real_rate == '0)
      else $error("failed search with nonzero fields");

   // a match splits the bit into sample point and segment two
   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bts_pkg::STATUS_OK ||
                    rsp_status == bts_pkg::STATUS_PRESC_BIG) |->
      rsp_quanta_per_bit >= bts_pkg::MIN_QUANTA &&
      rsp_quanta_per_bit <= bts_pkg::MAX_QUANTA &&
      rsp_sample_quanta + rsp_segment_two == rsp_quanta_per_bit)
      else $error("inconsistent bit split");

   // ok status keeps the prescaler in range
   a_presc_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bts_pkg::STATUS_OK |->
      rsp_prescaler <= bts_pkg::PRESC_W'(1024))
      else $error("prescaler out of range with ok status");

endmodule

bind can_bit_timing_search_unit bts_checker u_bts_checker (.*);

@@ sim/bts_timing_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_timing_checker
// watches the request, result and register channels of the bit timing
// search unit, predicts the timing for every accepted rate beat and compares
// each result beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module bts_timing_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [bts_pkg::RATE_W-1:0]        req_bit_rate,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [1:0]                        rsp_status,
   input  logic [bts_pkg::PRESC_W-1:0]       rsp_prescaler,
   input  logic [bts_pkg::QUANTA_W-1:0]      rsp_quanta_per_bit,
   input  logic [bts_pkg::QUANTA_W-1:0]      rsp_sample_quanta,
   input  logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_one,
   input  logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_two,
   input  logic [bts_pkg::JUMP_W-1:0]        rsp_jump_width,
   input  logic                              rsp_segments_in_range,
   input  logic [bts_pkg::RATE_W-1:0]        rsp_real_rate,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]    csr_data,
   output int unsigned                       outstanding,
   output int unsigned                       fail_count,
   output int unsigned                       ok_count,
   output int unsigned                       big_count,
   output int unsigned                       nofit_count,
   output int unsigned                       zero_count
);

   localparam longint unsigned PRESC_OK_MAX    = 1024;
   localparam longint unsigned PRESC_FIELD_MAX = (64'd1 << bts_pkg::PRESC_W) - 1;
   localparam int              REPORT_LIMIT    = 10;

   typedef struct packed {
      bts_pkg::status_type              status;
      logic [bts_pkg::PRESC_W-1:0]      prescaler;
      logic [bts_pkg::QUANTA_W-1:0]     quanta_per_bit;
      logic [bts_pkg::QUANTA_W-1:0]     sample_quanta;
      logic [bts_pkg::QUANTA_W-1:0]     segment_one;
      logic [bts_pkg::QUANTA_W-1:0]     segment_two;
      logic [bts_pkg::JUMP_W-1:0]       jump_width;
      logic                             segments_in_range;
      logic [bts_pkg::RATE_W-1:0]       real_rate;
   } bit_timing_type;

   bit_timing_type                 pending_timings [$];
   bit_timing_type                 seen;
   bit_timing_type                 wanted;
   logic [bts_pkg::CLOCK_W-1:0]    clock_hz_now;
   logic [bts_pkg::PERCENT_W-1:0]  percent_now;
   int unsigned                    bad_beats;
   int unsigned                    results_seen;
   int unsigned                    tally_ok, tally_big, tally_nofit, tally_zero;

   // bit timing for one requested rate under the current clock and percent
   function automatic bit_timing_type solve_timing(
         input logic [bts_pkg::RATE_W-1:0]    rate,
         input logic [bts_pkg::CLOCK_W-1:0]   clk_hz,
         input logic [bts_pkg::PERCENT_W-1:0] percent);
      bit_timing_type  t;
      longint unsigned q, chosen, quanta_freq, quot, sp, seg1, seg2, jump;
      bit              found;
      t      = '0;
      found  = 1'b0;
      chosen = 0;
      if (rate == '0) begin
         t.status = bts_pkg::STATUS_ZERO_RATE;
      end else begin
         // largest quanta count whose remainder stays under a 32nd of rate*q
         for (q = bts_pkg::MAX_QUANTA; q >= bts_pkg::MIN_QUANTA; q--) begin
            quanta_freq = rate * q;
            if (!found && (clk_hz % quanta_freq) < (quanta_freq >> 5)) begin
               found  = 1'b1;
               chosen = q;
            end
         end
         if (!found) begin
            t.status = bts_pkg::STATUS_NO_FIT;
         end else begin
            quanta_freq = rate * chosen;
            quot        = clk_hz / quanta_freq;
            t.status    = (quot > PRESC_OK_MAX) ? bts_pkg::STATUS_PRESC_BIG
                                                : bts_pkg::STATUS_OK;
            t.prescaler = (quot > PRESC_FIELD_MAX) ? '1 : bts_pkg::PRESC_W'(quot);
            // sample point in quanta, clipped to the bit length
            sp = (chosen * percent) / 100;
            if (sp > chosen)
               sp = chosen;
            seg2 = chosen - sp;
            seg1 = (sp > 0) ? sp - 1 : 0;
            jump = (seg2 > 5) ? 4 : ((seg2 > 0) ? seg2 - 1 : 0);
            t.quanta_per_bit    = bts_pkg::QUANTA_W'(chosen);
            t.sample_quanta     = bts_pkg::QUANTA_W'(sp);
            t.segment_one       = bts_pkg::QUANTA_W'(seg1);
            t.segment_two       = bts_pkg::QUANTA_W'(seg2);
            t.jump_width        = bts_pkg::JUMP_W'(jump);
            t.segments_in_range = (seg1 >= 1 && seg1 <= 16 && seg2 >= 1 && seg2 <= 8 &&
                                   jump >= 1 && jump <= 4);
            if (seg1 != 0 && seg2 != 0)
               t.real_rate = bts_pkg::RATE_W'(quanta_freq / (1 + seg1 + seg2));
         end
      end
      return t;
   endfunction

   function automatic string describe(input bit_timing_type t);
      return $sformatf({"status %0d presc %0d quanta %0d sample %0d seg1 %0d seg2 %0d ",
                        "sjw %0d in_range %0d real %0d"},
                       t.status, t.prescaler, t.quanta_per_bit, t.sample_quanta,
                       t.segment_one, t.segment_two, t.jump_width, t.segments_in_range,
                       t.real_rate);
   endfunction

   // channel monitor: register beats, rate beats, result beats
   always @(posedge clock) begin
      if (reset) begin
         clock_hz_now = bts_pkg::CLOCK_HZ_RESET;
         percent_now  = bts_pkg::PERCENT_RESET;
         pending_timings.delete();
         bad_beats    = 0;
         results_seen = 0;
         tally_ok     = 0;
         tally_big    = 0;
         tally_nofit  = 0;
         tally_zero   = 0;
      end else begin
         // register write beat
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bts_pkg::CSR_CLOCK_HZ:     clock_hz_now = csr_data[bts_pkg::CLOCK_W-1:0];
               bts_pkg::CSR_SAMPLE_POINT: percent_now  = csr_data[bts_pkg::PERCENT_W-1:0];
               default:                   ;
            endcase
         end

         // rate beat: queue the timing it should produce
         if (req_valid && req_ready)
            pending_timings.push_back(solve_timing(req_bit_rate, clock_hz_now, percent_now));

         // result beat: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            seen.status            = bts_pkg::status_type'(rsp_status);
            seen.prescaler         = rsp_prescaler;
            seen.quanta_per_bit    = rsp_quanta_per_bit;
            seen.sample_quanta     = rsp_sample_quanta;
            seen.segment_one       = rsp_segment_one;
            seen.segment_two       = rsp_segment_two;
            seen.jump_width        = rsp_jump_width;
            seen.segments_in_range = rsp_segments_in_range;
            seen.real_rate         = rsp_real_rate;
            if (pending_timings.size() == 0) begin
               bad_beats++;
               if (bad_beats <= REPORT_LIMIT)
                  $display("%0t: result beat %0d with no rate pending: %s",
                           $realtime, results_seen, describe(seen));
            end else begin
               wanted = pending_timings.pop_front();
               if (seen !== wanted) begin
                  bad_beats++;
                  if (bad_beats <= REPORT_LIMIT) begin
                     $display("%0t: result beat %0d mismatch", $realtime, results_seen);
                     $display("   expected %s", describe(wanted));
                     $display("   actual   %s", describe(seen));
                  end
               end
               case (wanted.status)
                  bts_pkg::STATUS_OK:        tally_ok++;
                  bts_pkg::STATUS_PRESC_BIG: tally_big++;
                  bts_pkg::STATUS_NO_FIT:    tally_nofit++;
                  default:                   tally_zero++;
               endcase
            end
         end
      end
      outstanding <= pending_timings.size();
      fail_count  <= bad_beats;
      ok_count    <= tally_ok;
      big_count   <= tally_big;
      nofit_count <= tally_nofit;
      zero_count  <= tally_zero;
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives rate requests and register writes into the bit timing search unit
// under several clock and sample point settings and idling patterns; the
// timing checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;

   localparam int LIMIT_CYCLES    = 3000000;
   localparam int GAP_CAP         = 60;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 60;
   localparam logic [bts_pkg::CSR_IDX_W-1:0] CSR_SPARE = bts_pkg::CSR_IDX_W'(8'hFE);

   logic                              clock        = 1'b0;
   logic                              reset        = 1'b1;
   logic                              req_valid    = 1'b0;
   logic [bts_pkg::RATE_W-1:0]        req_bit_rate = '0;
   logic                              rsp_ready    = 1'b0;
   logic                              csr_valid    = 1'b0;
   logic [bts_pkg::CSR_IDX_W-1:0]     csr_index    = '0;
   logic [bts_pkg::CSR_DATA_W-1:0]    csr_data     = '0;

   logic                              req_ready;
   logic                              rsp_valid;
   logic [1:0]                        rsp_status;
   logic [bts_pkg::PRESC_W-1:0]       rsp_prescaler;
   logic [bts_pkg::QUANTA_W-1:0]      rsp_quanta_per_bit;
   logic [bts_pkg::QUANTA_W-1:0]      rsp_sample_quanta;
   logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_one;
   logic [bts_pkg::QUANTA_W-1:0]      rsp_segment_two;
   logic [bts_pkg::JUMP_W-1:0]        rsp_jump_width;
   logic                              rsp_segments_in_range;
   logic [bts_pkg::RATE_W-1:0]        rsp_real_rate;
   logic                              csr_ready;

   int unsigned outstanding, fail_count, ok_count, big_count, nofit_count, zero_count;

   int                          req_idle_pct  = 0;
   int                          rsp_stall_pct = 0;
   int                          req_gap       = 0;
   bit                          req_held      = 1'b0;
   logic [bts_pkg::CLOCK_W-1:0] clock_now     = bts_pkg::CLOCK_HZ_RESET;
   int unsigned                 beats_sent    = 0;
   int unsigned                 settings_done = 0;
   int unsigned                 cycle_count   = 0;

   can_bit_timing_search_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_bit_rate          (req_bit_rate),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_prescaler         (rsp_prescaler),
      .rsp_quanta_per_bit    (rsp_quanta_per_bit),
      .rsp_sample_quanta     (rsp_sample_quanta),
      .rsp_segment_one       (rsp_segment_one),
      .rsp_segment_two       (rsp_segment_two),
      .rsp_jump_width        (rsp_jump_width),
      .rsp_segments_in_range (rsp_segments_in_range),
      .rsp_real_rate         (rsp_real_rate),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   bts_timing_checker timing_watch (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_bit_rate          (req_bit_rate),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_prescaler         (rsp_prescaler),
      .rsp_quanta_per_bit    (rsp_quanta_per_bit),
      .rsp_sample_quanta     (rsp_sample_quanta),
      .rsp_segment_one       (rsp_segment_one),
      .rsp_segment_two       (rsp_segment_two),
      .rsp_jump_width        (rsp_jump_width),
      .rsp_segments_in_range (rsp_segments_in_range),
      .rsp_real_rate         (rsp_real_rate),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .outstanding           (outstanding),
      .fail_count            (fail_count),
      .ok_count              (ok_count),
      .big_count             (big_count),
      .nofit_count           (nofit_count),
      .zero_count            (zero_count)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // receiver stalls at the rate of the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one rate beat; valid stays up into the next beat when no gap is drawn and it is not the last
   task automatic send_rate(input logic [bts_pkg::RATE_W-1:0] rate, input bit last);
      if (!req_held)
         repeat ((req_gap == 0) ? 1 : req_gap) @(posedge clock);
      req_valid    <= 1'b1;
      req_bit_rate <= rate;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      req_gap = 0;
      while (req_gap < GAP_CAP && $urandom_range(99) < req_idle_pct)
         req_gap++;
      req_held = !last && (req_gap == 0);
      if (!req_held)
         req_valid <= 1'b0;
   endtask

   // wait until every predicted result has come back
   task automatic drain();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // write both registers back to back, and an unused index if asked, once the block is idle
   task automatic program_timing(input logic [bts_pkg::CLOCK_W-1:0] clk_hz,
                                 input logic [bts_pkg::PERCENT_W-1:0] percent,
                                 input bit spare);
      drain();
      csr_valid <= 1'b1;
      csr_index <= bts_pkg::CSR_CLOCK_HZ;
      csr_data  <= clk_hz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // upper data bits are noise the register must drop
      csr_index <= bts_pkg::CSR_SAMPLE_POINT;
      csr_data  <= {(bts_pkg::CSR_DATA_W - bts_pkg::PERCENT_W)'($urandom), percent};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (spare) begin
         csr_index <= CSR_SPARE;
         csr_data  <= $urandom;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      clock_now = clk_hz;
      settings_done++;
   endtask

   // mostly rates near a divisor of the clock so the search finds a count
   function automatic logic [bts_pkg::RATE_W-1:0] pick_rate(
         input logic [bts_pkg::CLOCK_W-1:0] clk_hz);
      longint unsigned r, q, p;
      int              draw;
      draw = $urandom_range(99);
      if (draw < 55) begin
         q = $urandom_range(bts_pkg::MAX_QUANTA, bts_pkg::MIN_QUANTA);
         p = ($urandom_range(9) == 0) ? $urandom_range(4000, 1025) : $urandom_range(64, 1);
         r = clk_hz / (q * p);
      end else if (draw < 75) begin
         case ($urandom_range(8))
            0:       r = 10000;
            1:       r = 20000;
            2:       r = 50000;
            3:       r = 100000;
            4:       r = 125000;
            5:       r = 250000;
            6:       r = 500000;
            7:       r = 800000;
            default: r = 1000000;
         endcase
      end else if (draw < 92) begin
         r = $urandom_range(1000000, 1);
      end else begin
         r = $urandom_range((1 << bts_pkg::RATE_W) - 1, 0);
      end
      if (r >= (64'd1 << bts_pkg::RATE_W))
         r = $urandom_range(1000000, 1);
      return bts_pkg::RATE_W'(r);
   endfunction

   // cycle limit
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[can_bit_timing_search_unit] ERROR");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [bts_pkg::CLOCK_W-1:0]   clk_pick;
      logic [bts_pkg::PERCENT_W-1:0] pct_pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero rate, smallest rates, field extremes, bit patterns
      send_rate('0, 1'b0);
      send_rate(bts_pkg::RATE_W'(1), 1'b0);
      send_rate(bts_pkg::RATE_W'(2), 1'b0);
      send_rate(bts_pkg::RATE_W'(10), 1'b0);
      send_rate(bts_pkg::RATE_W'(1000), 1'b0);
      send_rate(bts_pkg::RATE_W'(125000), 1'b0);
      send_rate(bts_pkg::RATE_W'(500000), 1'b0);
      send_rate(bts_pkg::RATE_W'(1000000), 1'b0);
      send_rate('1, 1'b0);
      send_rate(bts_pkg::RATE_W'(20'h55555), 1'b0);
      send_rate(bts_pkg::RATE_W'(20'hAAAAA), 1'b1);

      // write to an unused index must leave the settings alone
      program_timing(bts_pkg::CLOCK_HZ_RESET, bts_pkg::PERCENT_RESET, 1'b1);
      send_rate(bts_pkg::RATE_W'(250000), 1'b1);

      // clock far below the quantum frequency gives a zero prescaler
      program_timing(bts_pkg::CLOCK_W'(1000), bts_pkg::PERCENT_RESET, 1'b0);
      send_rate(bts_pkg::RATE_W'(1000000), 1'b1);

      // zero clock, percent of 50
      program_timing('0, bts_pkg::PERCENT_W'(50), 1'b0);
      send_rate(bts_pkg::RATE_W'(1), 1'b0);
      send_rate(bts_pkg::RATE_W'(1000), 1'b1);

      // largest clock, percent above 100 clips the sample point
      program_timing('1, '1, 1'b0);
      send_rate(bts_pkg::RATE_W'(1000000), 1'b0);
      send_rate(bts_pkg::RATE_W'(8), 1'b1);

      // zero percent: sample point and segment one vanish
      program_timing(bts_pkg::CLOCK_W'(80000000), '0, 1'b0);
      send_rate(bts_pkg::RATE_W'(500000), 1'b1);

      program_timing(bts_pkg::CLOCK_W'(16000000), bts_pkg::PERCENT_W'(99), 1'b0);
      send_rate(bts_pkg::RATE_W'(1000000), 1'b1);

      // random phases, each with its own settings and idling pattern
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       clk_pick = bts_pkg::CLOCK_W'(42000000);
            1:       clk_pick = bts_pkg::CLOCK_W'(80000000);
            2:       clk_pick = bts_pkg::CLOCK_W'(16000000);
            3:       clk_pick = bts_pkg::CLOCK_W'(8000000);
            4:       clk_pick = $urandom;
            5:       clk_pick = bts_pkg::CLOCK_W'(36000000);
            6:       clk_pick = bts_pkg::CLOCK_W'(24000000);
            default: clk_pick = '1;
         endcase
         case (phase)
            1:       pct_pick = bts_pkg::PERCENT_W'(50);
            2:       pct_pick = bts_pkg::PERCENT_W'(99);
            4:       pct_pick = '1;
            6:       pct_pick = bts_pkg::PERCENT_W'(12);
            default: pct_pick = bts_pkg::PERCENT_W'($urandom_range(99, 50));
         endcase
         program_timing(clk_pick, pct_pick, 1'b0);
         case (phase % 4)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 82; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin req_idle_pct = 31; rsp_stall_pct = 31; end
         endcase
         for (int k = 0; k < ITEMS_PER_PHASE; k++)
            send_rate(pick_rate(clock_now), k == ITEMS_PER_PHASE - 1);
      end

      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d rate beats across %0d register settings and four idling patterns",
               beats_sent, settings_done + 1);
      $display("results by status: %0d ok, %0d prescaler over 1024, %0d no fit, %0d zero rate",
               ok_count, big_count, nofit_count, zero_count);
      if (fail_count == 0)
         $display("[can_bit_timing_search_unit] OK");
      else
         $display("[can_bit_timing_search_unit] ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bts_pkg.sv
rtl/bts_divider.sv
rtl/can_bit_timing_search_unit.sv
rtl/bts_checker.sv
sim/bts_timing_checker.sv
sim/testbench.sv
